// ----- hdl/threshold_mean_impulse_filter_assert.svh -----
// Assertion macros used by the filter RTL.
`ifndef THRESHOLD_MEAN_IMPULSE_FILTER_ASSERT_SVH
`define THRESHOLD_MEAN_IMPULSE_FILTER_ASSERT_SVH

// Same-cycle implication check.
`define TMIF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("filter implication check failed");

// Next-cycle implication check.
`define TMIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("filter next-cycle check failed");

`endif

// ----- hdl/tmif_pkg.sv -----
// Types and constants of the threshold mean impulse filter.
package tmif_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  localparam int CFG_DATA_W = 12;
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  // Input item codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_PAD   = 1'b1;

  // floor(x / 3) = (x * 683) >> 11 for x below 1536.
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       replaced;
    logic       frame_end;
  } out_t;

endpackage

// ----- hdl/threshold_mean_impulse_filter.sv -----
// A result passes the stage one, stage two and output queue registers before it is
// offered. An item is not taken while the previous one is in stage one, as the window
// sum, mean and compare loop feeds its corrected center value to the next window.
// Reset is synchronous and active low; it clears counters, pointers, the window and
// the output queue. Line and delay memory contents stay undefined until written.
`include "threshold_mean_impulse_filter_assert.svh"

module threshold_mean_impulse_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_index,
  input  logic [tmif_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tmif_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tmif_pkg::out_t                     out_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int DW   = CW + 1;
  localparam int HW   = RW + 1;
  localparam int RING = 2 * MAX_WIDTH + 2;
  localparam int RAW  = $clog2(RING);
  localparam int FW   = $clog2(RING + 1);
  localparam int EW   = $clog2(MAX_WIDTH * MAX_HEIGHT);

  typedef struct packed {
    logic           valid;
    logic           pad;
    logic           emit;
    logic           interior;
    logic [7:0]     gray;
    logic [23:0]    color;
    logic [CW-1:0]  ac;
    logic [1:0]     ar_lo;
    logic [RAW-1:0] push_addr;
    logic [RAW-1:0] corr_addr;
    logic           corr_head;
  } s1_t;

  typedef struct packed {
    logic           valid;
    logic           emit;
    logic           interior;
    logic [CW-1:0]  ac;
    logic [1:0]     ar_lo;
    logic [RAW-1:0] corr_addr;
    logic           corr_head;
    logic [12:0]    sum;
    logic [7:0]     centre;
  } s2_t;

  // Configuration registers.
  logic [11:0] cfg_w_r, cfg_h_r;
  logic [7:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= tmif_pkg::FRAME_WIDTH_RST;
      cfg_h_r <= tmif_pkg::FRAME_HEIGHT_RST;
      thr_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tmif_pkg::REG_FRAME_WIDTH:  cfg_w_r <= cfg_data;
        tmif_pkg::REG_FRAME_HEIGHT: cfg_h_r <= cfg_data;
        tmif_pkg::REG_THRESHOLD:    thr_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry and the derived delay depth.
  logic [DW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [FW-1:0] depth_c;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_c = DW'(1);
    end else if (32'(cfg_w_r) > 32'(MAX_WIDTH)) begin
      w_c = DW'(MAX_WIDTH);
    end else begin
      w_c = DW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_c = HW'(1);
    end else if (32'(cfg_h_r) > 32'(MAX_HEIGHT)) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(cfg_h_r);
    end
    depth_c = (FW'(w_c) << 1) + FW'(2);
  end

  // Index of the last pixel of a frame, registered off the multiplier.
  logic [EW-1:0] last_r;

  always_ff @(posedge clk) begin
    last_r <= EW'((DW + HW)'(w_c) * (DW + HW)'(h_c) - (DW + HW)'(1));
  end

  // Pipeline, counters and queue state.
  s1_t            s1_r;
  s2_t            s2_r;
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [RAW-1:0] rd_r;
  logic [FW-1:0]  fill_r;
  logic [EW-1:0]  emitted_r;
  logic [7:0]     win_r [5][5];
  logic [7:0]     win_n [5][5];
  tmif_pkg::out_t oq_r [2];
  logic           oq_wp_r, oq_rp_r;
  logic [1:0]     oq_cnt_r;

  logic in_accept, is_pad, px_accept;

  // Accept only when stage one is empty and the queue has room for the results in flight.
  always_comb begin
    in_stall = s1_r.valid || (oq_cnt_r == 2'd2) ||
               (oq_cnt_r == 2'd1 && s2_r.valid && s2_r.emit);
  end

  assign in_accept = in_valid && !in_stall;
  assign is_pad    = (in_data.cmd == tmif_pkg::CMD_PAD);
  assign px_accept = in_accept && !is_pad;

  // Gray value and delay ring addressing at acceptance.
  logic [12:0]    gray_sum;
  logic           emit_c;
  logic [FW:0]    push_sum, corr_sum;
  logic [RAW-1:0] push_addr_c, corr_addr_c, rd_inc_c;

  always_comb begin
    gray_sum = 13'd11 * 13'(in_data.red_in) + 13'd16 * 13'(in_data.green_in) +
               13'd5 * 13'(in_data.blue_in);
    emit_c   = is_pad ? (fill_r != '0) : (fill_r >= depth_c);
    push_sum = (FW + 1)'(rd_r) + (FW + 1)'(fill_r);
    if (push_sum >= (FW + 1)'(RING)) begin
      push_sum = push_sum - (FW + 1)'(RING);
    end
    push_addr_c = RAW'(push_sum);
    corr_sum = (FW + 1)'(rd_r) + (FW + 1)'(fill_r - depth_c);
    if (corr_sum >= (FW + 1)'(RING)) begin
      corr_sum = corr_sum - (FW + 1)'(RING);
    end
    corr_addr_c = RAW'(corr_sum);
    if (32'(rd_r) == RING - 1) begin
      rd_inc_c = '0;
    end else begin
      rd_inc_c = rd_r + RAW'(1);
    end
  end

  // Stage one capture, pointers and raster counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      rd_r       <= '0;
      fill_r     <= '0;
    end else begin
      s1_r.valid <= in_accept;
      if (in_accept) begin
        if (emit_c) begin
          rd_r <= rd_inc_c;
        end
        fill_r <= fill_r - FW'(emit_c) + FW'(!is_pad);
      end
      if (px_accept) begin
        if (DW'(col_r) + DW'(1) >= w_c) begin
          col_r <= '0;
          if (HW'(row_r) + HW'(1) >= h_c) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
    if (in_accept) begin
      s1_r.pad       <= is_pad;
      s1_r.emit      <= emit_c;
      s1_r.interior  <= !is_pad && col_r >= CW'(4) && row_r >= RW'(4) &&
                        DW'(col_r) < w_c && HW'(row_r) < h_c;
      s1_r.gray      <= gray_sum[12:5];
      s1_r.color     <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      s1_r.ac        <= col_r;
      s1_r.ar_lo     <= row_r[1:0];
      s1_r.push_addr <= push_addr_c;
      s1_r.corr_addr <= corr_addr_c;
      s1_r.corr_head <= (fill_r == depth_c);
    end
  end

  // Line store: four gray rows packed per column, one byte lane each.
  logic [3:0][7:0] lmem [MAX_WIDTH];
  logic [3:0][7:0] lm_rdata_r;
  logic            lm_fwd_r;
  logic [1:0]      lm_fwd_lane_r;
  logic [7:0]      lm_fwd_data_r;
  logic [3:0][7:0] lm_rd_c;
  logic            lm_we;
  logic [CW-1:0]   lm_waddr;
  logic [1:0]      lm_lane;
  logic [7:0]      lm_wdata;

  // Decision for the window center.
  logic [19:0] div_prod;
  logic [7:0]  mean_c, diff_c;
  logic        replace_c;

  always_comb begin
    div_prod  = 20'(s2_r.sum[12:3]) * 20'(tmif_pkg::DIV3_MUL);
    mean_c    = div_prod[tmif_pkg::DIV3_SHIFT +: 8];
    diff_c    = (s2_r.centre > mean_c) ? s2_r.centre - mean_c : mean_c - s2_r.centre;
    replace_c = s2_r.valid && s2_r.interior && (diff_c > thr_r);
  end

  // Gray write on stage one, correction write on stage two; they never coincide.
  always_comb begin
    if (s1_r.valid && !s1_r.pad) begin
      lm_we    = 1'b1;
      lm_waddr = s1_r.ac;
      lm_lane  = s1_r.ar_lo;
      lm_wdata = s1_r.gray;
    end else begin
      lm_we    = replace_c;
      lm_waddr = s2_r.ac - CW'(2);
      lm_lane  = s2_r.ar_lo + 2'd2;
      lm_wdata = mean_c;
    end
  end

  // A write to the column being read in the same cycle is kept aside and merged later.
  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[lm_waddr][lm_lane] <= lm_wdata;
    end
    if (px_accept) begin
      lm_rdata_r    <= lmem[col_r];
      lm_fwd_r      <= lm_we && (lm_waddr == col_r);
      lm_fwd_lane_r <= lm_lane;
      lm_fwd_data_r <= lm_wdata;
    end
  end

  always_comb begin
    lm_rd_c = lm_rdata_r;
    if (lm_fwd_r) begin
      lm_rd_c[lm_fwd_lane_r] = lm_fwd_data_r;
    end
  end

  // Color delay ring: color plus replaced flag.
  logic [24:0]    ring [RING];
  logic [24:0]    ring_rdata_r;
  logic           rg_we;
  logic [RAW-1:0] rg_waddr;
  logic [24:0]    rg_wdata;

  always_comb begin
    if (s1_r.valid && !s1_r.pad) begin
      rg_we    = 1'b1;
      rg_waddr = s1_r.push_addr;
      rg_wdata = {1'b0, s1_r.color};
    end else begin
      rg_we    = replace_c && s2_r.emit && !s2_r.corr_head;
      rg_waddr = s2_r.corr_addr;
      rg_wdata = {1'b1, mean_c, mean_c, mean_c};
    end
  end

  always_ff @(posedge clk) begin
    if (rg_we) begin
      ring[rg_waddr] <= rg_wdata;
    end
    if (in_accept) begin
      if (rg_we && rg_waddr == rd_r) begin
        ring_rdata_r <= rg_wdata;
      end else begin
        ring_rdata_r <= ring[rd_r];
      end
    end
  end

  // Window shift with the new column and the 24-neighbor sum.
  logic [12:0] sum_n;
  logic [10:0] row_sum [5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) begin
        win_n[i][j] = win_r[i][j + 1];
      end
    end
    for (int i = 0; i < 4; i++) begin
      win_n[i][4] = lm_rd_c[2'(s1_r.ar_lo + 2'(i))];
    end
    win_n[4][4] = s1_r.gray;
    for (int i = 0; i < 5; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < 5; j++) begin
        if (!(i == 2 && j == 2)) begin
          row_sum[i] = row_sum[i] + 11'(win_n[i][j]);
        end
      end
    end
    sum_n = 13'(row_sum[0]) + 13'(row_sum[1]) + 13'(row_sum[2]) +
            13'(row_sum[3]) + 13'(row_sum[4]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_r.valid && !s1_r.pad) begin
      win_r <= win_n;
    end else if (replace_c) begin
      win_r[2][2] <= mean_c;
    end
  end

  // Stage two capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s1_r.valid;
    end
    if (s1_r.valid) begin
      s2_r.emit      <= s1_r.emit;
      s2_r.interior  <= s1_r.interior;
      s2_r.ac        <= s1_r.ac;
      s2_r.ar_lo     <= s1_r.ar_lo;
      s2_r.corr_addr <= s1_r.corr_addr;
      s2_r.corr_head <= s1_r.corr_head;
      s2_r.sum       <= sum_n;
      s2_r.centre    <= win_n[2][2];
    end
  end

  // Result formation and the two-entry output queue.
  logic           land, pop, frame_end_c;
  tmif_pkg::out_t res_c;

  always_comb begin
    land        = s2_r.valid && s2_r.emit;
    frame_end_c = (emitted_r >= last_r);
    if (replace_c && s2_r.corr_head) begin
      res_c.red_out   = mean_c;
      res_c.green_out = mean_c;
      res_c.blue_out  = mean_c;
      res_c.replaced  = 1'b1;
    end else begin
      res_c.red_out   = ring_rdata_r[23:16];
      res_c.green_out = ring_rdata_r[15:8];
      res_c.blue_out  = ring_rdata_r[7:0];
      res_c.replaced  = ring_rdata_r[24];
    end
    res_c.frame_end = frame_end_c;
  end

  assign out_valid = (oq_cnt_r != '0);
  assign out_data  = oq_r[oq_rp_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r   <= 1'b0;
      oq_rp_r   <= 1'b0;
      oq_cnt_r  <= '0;
      emitted_r <= '0;
    end else begin
      if (land) begin
        oq_wp_r   <= !oq_wp_r;
        emitted_r <= frame_end_c ? '0 : emitted_r + EW'(1);
      end
      if (pop) begin
        oq_rp_r <= !oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(land) - 2'(pop);
    end
    if (land) begin
      oq_r[oq_wp_r] <= res_c;
    end
  end

  // Checks on the pipeline and queue.
  `TMIF_ASSERT_IMP(a_single_item, clk, rst_n, s1_r.valid, !s2_r.valid)
  `TMIF_ASSERT_IMP(a_queue_room, clk, rst_n, s2_r.valid && s2_r.emit, oq_cnt_r <= 2'd1)
  `TMIF_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, 32'(fill_r) <= RING)
  `TMIF_ASSERT_NEXT(a_accept_tracked, clk, rst_n, in_valid && !in_stall, s1_r.valid)

endmodule

// ----- sim/tmif_checker.sv -----
// Checker for the threshold mean impulse filter: channel monitor, predictor and scoreboard.
module tmif_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [tmif_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  tmif_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  tmif_pkg::out_t                  out_data,
  output int                              error_count,
  output int                              pending_pixels
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX  = 2048;
  localparam int ROWS_MAX  = 2048;
  localparam int DELAY_LEN = 2 * LINE_MAX + 2;

  // Predictor copy of the configuration and the filter state.
  logic [11:0]    width_reg;
  logic [11:0]    height_reg;
  logic [7:0]     thresh_reg;
  logic [7:0]     line_gray [4*LINE_MAX];
  logic [24:0]    delay_ring [DELAY_LEN];
  logic [7:0]     win [5][5];
  int unsigned    ring_rd;
  int unsigned    ring_fill;
  int unsigned    col_pos;
  int unsigned    row_pos;
  int unsigned    emitted;
  tmif_pkg::out_t expected_pixels[$];

  initial begin
    error_count = 0;
    pending_pixels = 0;
  end

  function automatic int unsigned line_addr(int unsigned slot, int unsigned col);
    if (col >= LINE_MAX) col = LINE_MAX - 1;
    return (slot % 4) * LINE_MAX + col;
  endfunction

  // Take the oldest delayed pixel out of the ring.
  function automatic tmif_pkg::out_t pop_delayed(int unsigned w, int unsigned h);
    tmif_pkg::out_t px;
    logic [24:0]    e;
    bit             last;
    e = delay_ring[ring_rd % DELAY_LEN];
    last = (emitted >= w * h - 1);
    px.red_out   = e[23:16];
    px.green_out = e[15:8];
    px.blue_out  = e[7:0];
    px.replaced  = e[24];
    px.frame_end = last;
    emitted = last ? 0 : ((emitted + 1) & 32'h3FFFFF);
    ring_rd = (ring_rd + 1) % DELAY_LEN;
    ring_fill--;
    return px;
  endfunction

  // Advance the filter by one transaction; returns 1 when a pixel leaves.
  function automatic bit filter_step(tmif_pkg::in_t it, output tmif_pkg::out_t px);
    int unsigned w, h, depth, gray, ac, ar, sum, mean, centre, diff, pos;
    bit          produced;
    produced = 0;
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > ROWS_MAX) ? ROWS_MAX : height_reg);
    depth = 2 * w + 2;
    if (it.cmd == tmif_pkg::CMD_PAD) begin
      if (ring_fill == 0) return 0;
      px = pop_delayed(w, h);
      return 1;
    end
    gray = (11 * it.red_in + 16 * it.green_in + 5 * it.blue_in) >> 5;
    ac = col_pos;
    ar = row_pos;
    // Shift the window left and load the new column.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        win[i][j] = win[i][j+1];
    for (int i = 0; i < 4; i++)
      win[i][4] = line_gray[line_addr(ar + i, ac)];
    win[4][4] = gray[7:0];
    line_gray[line_addr(ar, ac)] = gray[7:0];
    // Decide the center pixel when the whole window lies inside the frame.
    if (ac >= 4 && ar >= 4 && ac < w && ar < h) begin
      sum = 0;
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++)
          sum += win[i][j];
      centre = win[2][2];
      sum -= centre;
      mean = sum / 24;
      diff = (centre > mean) ? centre - mean : mean - centre;
      if (diff > thresh_reg) begin
        win[2][2] = mean[7:0];
        line_gray[line_addr(ar + 2, ac - 2)] = mean[7:0];
        if (ring_fill >= depth) begin
          pos = (ring_rd + ring_fill - depth) % DELAY_LEN;
          delay_ring[pos] = {1'b1, mean[7:0], mean[7:0], mean[7:0]};
        end
      end
    end
    if (ring_fill >= depth) begin
      px = pop_delayed(w, h);
      produced = 1;
    end
    delay_ring[(ring_rd + ring_fill) % DELAY_LEN] =
      {1'b0, it.red_in, it.green_in, it.blue_in};
    ring_fill++;
    if (ac + 1 >= w) begin
      col_pos = 0;
      row_pos = (ar + 1 >= h) ? 0 : ar + 1;
    end else begin
      col_pos = ac + 1;
    end
    return produced;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin
    tmif_pkg::out_t want;
    tmif_pkg::out_t px;
    if (!rst_n) begin
      width_reg  = tmif_pkg::FRAME_WIDTH_RST;
      height_reg = tmif_pkg::FRAME_HEIGHT_RST;
      thresh_reg = '0;
      ring_rd = 0;
      ring_fill = 0;
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++)
          win[i][j] = '0;
      expected_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected output transaction", 1, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.red_out !== want.red_out)
            report_mismatch("red_out", out_data.red_out, want.red_out);
          if (out_data.green_out !== want.green_out)
            report_mismatch("green_out", out_data.green_out, want.green_out);
          if (out_data.blue_out !== want.blue_out)
            report_mismatch("blue_out", out_data.blue_out, want.blue_out);
          if (out_data.replaced !== want.replaced)
            report_mismatch("replaced", out_data.replaced, want.replaced);
          if (out_data.frame_end !== want.frame_end)
            report_mismatch("frame_end", out_data.frame_end, want.frame_end);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          tmif_pkg::REG_FRAME_WIDTH:  width_reg = cfg_data;
          tmif_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
          tmif_pkg::REG_THRESHOLD:    thresh_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (filter_step(in_data, px)) expected_pixels.push_back(px);
      end
    end
    pending_pixels = expected_pixels.size();
  end
endmodule

// ----- sim/tb_top.sv -----
// Top of the filter testbench: clock, reset, stimulus, stall pattern and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [1:0]                      cfg_index = tmif_pkg::REG_FRAME_WIDTH;
  logic [tmif_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  tmif_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  tmif_pkg::out_t                  out_data;
  int                              error_count;
  int                              pending_pixels;
  int                              cycle_count = 0;
  int                              sent_count = 0;
  bit                              steady_sender = 0;
  bit                              hold_req = 0;
  int unsigned                     cur_width = 640;

  always #10 clk = ~clk;

  threshold_mean_impulse_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tmif_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .error_count(error_count), .pending_pixels(pending_pixels)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off once the stimulus asks for it,
  // and a quiet stretch with no stalls at all.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= ($urandom_range(99) < 30);
      end else if (cycle_count > 1500 && cycle_count < 2100) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  // Offer one transaction and hold it until accepted, then maybe idle.
  task automatic send_item(tmif_pkg::in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (!steady_sender && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    tmif_pkg::in_t it;
    it.cmd = tmif_pkg::CMD_PIXEL;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    send_item(it);
  endtask

  task automatic send_pad();
    tmif_pkg::in_t it;
    it = tmif_pkg::in_t'($urandom);
    it.cmd = tmif_pkg::CMD_PAD;
    send_item(it);
  endtask

  // One register write, after which the write enable is driven low again.
  task automatic write_reg(logic [1:0] idx, logic [tmif_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the delay line with padding and wait for the block to go idle.
  task automatic drain_and_idle();
    repeat (2 * cur_width + 3) send_pad();
    in_valid <= 1'b0;
    wait (pending_pixels == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned thr);
    write_reg(tmif_pkg::REG_FRAME_WIDTH, tmif_pkg::CFG_DATA_W'(w));
    write_reg(tmif_pkg::REG_FRAME_HEIGHT, tmif_pkg::CFG_DATA_W'(h));
    write_reg(tmif_pkg::REG_THRESHOLD, tmif_pkg::CFG_DATA_W'(thr));
    cur_width = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
  endtask

  // One frame of a flat-ish image with random impulses; optional mid-frame padding.
  task automatic send_frame(int unsigned w, int unsigned h, bit with_pads);
    logic [7:0] base;
    logic [7:0] r, g, b;
    base = 8'($urandom);
    for (int k = 0; k < w * h; k++) begin
      if ($urandom_range(99) < 12) begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end else begin
        r = base + 8'($urandom_range(0, 6));
        g = base + 8'($urandom_range(0, 6));
        b = base + 8'($urandom_range(0, 6));
      end
      send_pixel(r, g, b);
      if (with_pads && $urandom_range(99) < 3) send_pad();
    end
  endtask

  initial begin
    int unsigned w, h, thr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: padding on an empty block, then a 5x5 frame with extreme values.
    send_pad();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    set_geometry(5, 5, 0);
    for (int k = 0; k < 25; k++) begin
      case (k % 4)
        0: send_pixel(8'h00, 8'h00, 8'h00);
        1: send_pixel(8'hFF, 8'hFF, 8'hFF);
        2: send_pixel(8'hAA, 8'h55, 8'hF0);
        default: send_pixel(8'h0F, 8'hC3, 8'h3C);
      endcase
    end
    drain_and_idle();

    // Zero width counts as one; tiny frames pass unchanged.
    set_geometry(0, 3, 255);
    send_frame(1, 3, 0);
    drain_and_idle();
    set_geometry(4, 4, 5);
    send_frame(4, 4, 0);
    drain_and_idle();

    // Random frames, back to back within each setting; the receiver holds off once.
    hold_req = 1'b1;
    while (sent_count < 1100) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 9);
      case ($urandom_range(3))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(0, 40);
      endcase
      set_geometry(w, h, thr);
      repeat ($urandom_range(1, 3)) begin
        steady_sender = (sent_count > 300 && sent_count < 550);
        send_frame(w, h, 1);
      end
      steady_sender = 0;
      drain_and_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_pixels == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tmif_pkg.sv
hdl/threshold_mean_impulse_filter.sv
sim/tmif_checker.sv
sim/tb_top.sv
